@@ sv/qkpt_pkg.sv @@
package qkpt_pkg;

  // Fixed widths of the fields and of the arithmetic.
  localparam int SAMPLE_WIDTH = 16;
  localparam int PHASE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CNT_W        = 5;
  localparam int GUARD_BITS   = 8;
  localparam int QUO_W        = 17;
  localparam int VEC_W        = 36;
  localparam int ROT_W        = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int ROT_Z_W      = 34;
  localparam int KINV_W       = 31;
  localparam logic signed [KINV_W-1:0] KINV_Q30 = 31'sd652032874;
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_INIT_PHASE  = 2'd0,
    CFG_NOISE_RATIO = 2'd1,
    CFG_INITIAL_B   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
    logic signed [15:0] train_i;
    logic signed [15:0] train_q;
    logic               is_training;
    logic               frame_start;
    logic               last_of_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic signed [15:0] phase_estimate;
    logic               frame_end;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             prod;
    logic             vec_init;
    logic             vec_step;
    logic             div_init;
    logic             div_step;
    logic             kmul;
    logic             phase_upd;
    logic             rot_init;
    logic             rot_step;
    logic             scale_mul;
    logic             out_load;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic training;
    logic out_free;
  } dp_status_t;

  // Arctangent table, binary angle with 32 fraction bits.
  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10680862;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41722;
      4'd15:   v = 32'd20861;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/qkpt_in_if.sv @@
interface qkpt_in_if;
  import qkpt_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/qkpt_out_if.sv @@
interface qkpt_out_if;
  import qkpt_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/qkpt_ctrl.sv @@
module qkpt_ctrl
  import qkpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_VINIT, S_VEC, S_DINIT, S_DIV, S_KMUL, S_PUPD,
    S_RINIT, S_ROT, S_SMUL, S_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  // Command decode from the current state.
  always_comb begin
    cmd           = '0;
    cmd.step      = cnt[STEP_W-1:0];
    cmd.load      = in_ready && in_valid;
    cmd.prod      = (state == S_PROD);
    cmd.vec_init  = (state == S_VINIT);
    cmd.vec_step  = (state == S_VEC);
    cmd.div_init  = (state == S_DINIT);
    cmd.div_step  = (state == S_DIV);
    cmd.kmul      = (state == S_KMUL);
    cmd.phase_upd = (state == S_PUPD);
    cmd.rot_init  = (state == S_RINIT);
    cmd.rot_step  = (state == S_ROT);
    cmd.scale_mul = (state == S_SMUL);
    cmd.out_load  = (state == S_OUT) && status.out_free;
  end

  // Sequencer over the steps of one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_PROD;
        S_PROD:  state <= S_VINIT;
        S_VINIT: begin
          cnt   <= '0;
          state <= S_VEC;
        end
        S_VEC: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) state <= S_DINIT;
        end
        S_DINIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QUO_W - 1)) state <= S_KMUL;
        end
        S_KMUL:  state <= S_PUPD;
        S_PUPD:  state <= status.training ? S_IDLE : S_RINIT;
        S_RINIT: begin
          cnt   <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) state <= S_SMUL;
        end
        S_SMUL:  state <= S_OUT;
        S_OUT:   if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/qkpt_datapath.sv @@
module qkpt_datapath
  import qkpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  in_item_t    in_data,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output out_item_t   out_data,
  output logic        out_valid,
  input  logic        out_ready
);

  // Configuration and tracking state.
  logic [15:0] init_phase;
  logic [23:0] noise_ratio;
  logic [31:0] initial_b;
  logic [15:0] phase_est;
  logic [31:0] gain_state;

  // Item and work registers.
  in_item_t                 item;
  logic signed [31:0]       p_ii, p_qq, p_qi, p_iq;
  logic signed [VEC_W-1:0]  vx, vy;
  logic [31:0]              vz;
  logic                     vzero;
  logic [32:0]              e_sum;
  logic [33:0]              rem_k, rem_b;
  logic [QUO_W-1:0]         num_k, num_b, quo_k, quo_b;
  logic signed [33:0]       kprod;
  logic signed [ROT_W-1:0]  rx, ry;
  logic signed [ROT_Z_W-1:0] rz;
  logic signed [ROT_W+KINV_W-1:0] sx, sy;

  // Vector setup for the angle measurement.
  logic signed [VEC_W-1:0] xs, ys;
  always_comb begin
    if (item.is_training) begin
      xs = VEC_W'(p_ii) + VEC_W'(p_qq);
      ys = VEC_W'(p_qi) - VEC_W'(p_iq);
    end else begin
      xs = VEC_W'(item.sample_i);
      ys = VEC_W'(item.sample_q);
    end
  end

  // Measured angle, residual and the phase step.
  logic [31:0]        vz_rnd;
  logic [15:0]        ang, dphase;
  logic signed [15:0] res;
  logic [QUO_W-1:0]   k_val;
  logic               e_zero;
  logic signed [33:0] kp_rnd;
  always_comb begin
    vz_rnd = vz + 32'd32768;
    ang    = vzero ? 16'd0 : vz_rnd[31:16];
    dphase = ang - phase_est;
    if (item.is_training) res = dphase;
    else res = 16'({2'b00, dphase[13:0]}) - 16'sd8192;
    e_zero = (e_sum == 33'd0);
    k_val  = e_zero ? '0 : quo_k;
    kp_rnd = kprod + 34'sd32768;
  end

  // Division steps for k and the new gain.
  logic [33:0] rk2, rb2;
  always_comb begin
    rk2 = {rem_k[32:0], num_k[QUO_W-1]};
    rb2 = {rem_b[32:0], num_b[QUO_W-1]};
  end

  // Rotation setup and output scaling.
  logic signed [ROT_Z_W-1:0] theta;
  logic signed [ROT_W+KINV_W-1:0] sx_rnd, sy_rnd;
  logic signed [19:0] ox, oy;
  always_comb begin
    theta  = ROT_Z_W'($signed({16'd0 - phase_est, 16'd0}));
    sx_rnd = sx + (ROT_W+KINV_W)'(64'sd1 <<< 37);
    sy_rnd = sy + (ROT_W+KINV_W)'(64'sd1 <<< 37);
    ox     = 20'(sx_rnd >>> 38);
    oy     = 20'(sy_rnd >>> 38);
  end

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sd32767;
    else if (v < -20'sd32768) r = -16'sd32768;
    else r = v[15:0];
    return r;
  endfunction

  // Control state: configuration, tracking state and output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_phase  <= '0;
      noise_ratio <= 24'd65536;
      initial_b   <= ONE_Q16;
      phase_est   <= '0;
      gain_state  <= ONE_Q16;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_INIT_PHASE:  init_phase  <= cfg_wdata[15:0];
          CFG_NOISE_RATIO: noise_ratio <= cfg_wdata[23:0];
          CFG_INITIAL_B:   initial_b   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load && in_data.frame_start) begin
        phase_est  <= init_phase;
        gain_state <= initial_b;
      end
      if (cmd.phase_upd) begin
        phase_est  <= phase_est + kp_rnd[31:16];
        gain_state <= e_zero ? ONE_Q16 : ONE_Q16 + 32'(quo_b);
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_load) out_valid <= 1'b1;
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.prod) begin
      p_ii <= item.sample_i * item.train_i;
      p_qq <= item.sample_q * item.train_q;
      p_qi <= item.sample_q * item.train_i;
      p_iq <= item.sample_i * item.train_q;
    end
    // Vectoring CORDIC, one step per cycle.
    if (cmd.vec_init) begin
      vzero <= (xs == '0) && (ys == '0);
      if (xs < 0) begin
        vx <= -xs;
        vy <= -ys;
        vz <= 32'h8000_0000;
      end else begin
        vx <= xs;
        vy <= ys;
        vz <= '0;
      end
    end
    if (cmd.vec_step) begin
      if (vy >= 0) begin
        vx <= vx + (vy >>> cmd.step);
        vy <= vy - (vx >>> cmd.step);
        vz <= vz + atan_entry(cmd.step);
      end else begin
        vx <= vx - (vy >>> cmd.step);
        vy <= vy + (vx >>> cmd.step);
        vz <= vz - atan_entry(cmd.step);
      end
    end
    // Two restoring dividers sharing the divisor a + b.
    if (cmd.div_init) begin
      e_sum <= 33'(noise_ratio) + 33'(gain_state);
      rem_k <= 34'(noise_ratio[23:1]);
      rem_b <= 34'(gain_state[31:1]);
      num_k <= {noise_ratio[0], 16'd0};
      num_b <= {gain_state[0], 16'd0};
    end
    if (cmd.div_step) begin
      num_k <= {num_k[QUO_W-2:0], 1'b0};
      num_b <= {num_b[QUO_W-2:0], 1'b0};
      if (rk2 >= 34'(e_sum)) begin
        rem_k <= rk2 - 34'(e_sum);
        quo_k <= {quo_k[QUO_W-2:0], 1'b1};
      end else begin
        rem_k <= rk2;
        quo_k <= {quo_k[QUO_W-2:0], 1'b0};
      end
      if (rb2 >= 34'(e_sum)) begin
        rem_b <= rb2 - 34'(e_sum);
        quo_b <= {quo_b[QUO_W-2:0], 1'b1};
      end else begin
        rem_b <= rb2;
        quo_b <= {quo_b[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.kmul) kprod <= $signed({1'b0, k_val}) * res;
    // Rotation CORDIC by minus the phase.
    if (cmd.rot_init) begin
      if (theta > (ROT_Z_W'(64'sd1 <<< 30))) begin
        rx <= -ROT_W'($signed({item.sample_i, 8'd0}));
        ry <= -ROT_W'($signed({item.sample_q, 8'd0}));
        rz <= theta - (ROT_Z_W'(64'sd1 <<< 31));
      end else if (theta < -(ROT_Z_W'(64'sd1 <<< 30))) begin
        rx <= -ROT_W'($signed({item.sample_i, 8'd0}));
        ry <= -ROT_W'($signed({item.sample_q, 8'd0}));
        rz <= theta + (ROT_Z_W'(64'sd1 <<< 31));
      end else begin
        rx <= ROT_W'($signed({item.sample_i, 8'd0}));
        ry <= ROT_W'($signed({item.sample_q, 8'd0}));
        rz <= theta;
      end
    end
    if (cmd.rot_step) begin
      if (rz >= 0) begin
        rx <= rx - (ry >>> cmd.step);
        ry <= ry + (rx >>> cmd.step);
        rz <= rz - ROT_Z_W'(atan_entry(cmd.step));
      end else begin
        rx <= rx + (ry >>> cmd.step);
        ry <= ry - (rx >>> cmd.step);
        rz <= rz + ROT_Z_W'(atan_entry(cmd.step));
      end
    end
    if (cmd.scale_mul) begin
      sx <= rx * KINV_Q30;
      sy <= ry * KINV_Q30;
    end
    if (cmd.out_load) begin
      out_data.out_i          <= sat16(ox);
      out_data.out_q          <= sat16(oy);
      out_data.phase_estimate <= phase_est;
      out_data.frame_end      <= item.last_of_frame;
    end
  end

  assign status.training = item.is_training;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ sv/qpsk_kalman_phase_tracker_core.sv @@
// Channel  Dir  Payload                                             Handshake
// in_ch    in   sample_i/q, train_i/q, is_training, frame_start,    valid/ready
//               last_of_frame
// out_ch   out  out_i, out_q, phase_estimate, frame_end             valid/ready
// cfg      in   cfg_wr_en, cfg_index, cfg_wdata                     write only
//
// A data item's result is registered in the output register, and the next item
// can be taken in the cycle after; a training item ends after the phase update
// and gives no result. The two 16-step CORDICs and the 17-step divider each run
// one step per cycle. One item is worked on at a time.
// Reset is synchronous and active high.
// A stalled output holds the last step until the output register frees.
module qpsk_kalman_phase_tracker_core
  import qkpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  qkpt_in_if.sink     in_ch,
  qkpt_out_if.source  out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  qkpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  qkpt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule

@@ tb/qkpt_tracker_monitor.sv @@
module qkpt_tracker_monitor
  import qkpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  qkpt_in_if          in_ch,
  qkpt_out_if         out_ch,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Arctangent steps as binary angles with 32 fraction bits.
  localparam longint ATAN_STEP [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };
  localparam longint GAIN_COMP = 652032874;

  // Tracker state and register copies.
  logic [15:0] phase_acc;
  logic [31:0] gain_b;
  logic [15:0] init_phase_reg;
  logic [23:0] noise_ratio_reg;
  logic [31:0] initial_b_reg;

  out_item_t expected_q[$];

  initial pending = 0;

  // Angle of the vector (x, y) as a 16-bit binary angle; zero vector gives 0.
  function automatic logic [15:0] angle_of(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = 32'd0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_STEP[i][31:0];
      end else begin
        x -= dx; y += dy; z -= ATAN_STEP[i][31:0];
      end
    end
    z = z + 32'h0000_8000;
    return z[31:16];
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Rotates the sample by minus the phase with guard bits and gain compensation.
  function automatic void derotate(longint si, longint sq, logic [15:0] ph,
                                   output logic [15:0] oi, output logic [15:0] oq);
    logic [31:0] theta;
    longint z, x, y, dx, dy;
    theta = 32'd0 - {ph, 16'd0};
    z = longint'($signed(theta));
    x = si * 256;
    y = sq * 256;
    if (z > 64'sd1073741824) begin
      x = -x; y = -y; z -= 64'sd2147483648;
    end else if (z < -64'sd1073741824) begin
      x = -x; y = -y; z += 64'sd2147483648;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[i];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[i];
      end
    end
    oi = clip16((x * GAIN_COMP + (64'sd1 << 37)) >>> 38);
    oq = clip16((y * GAIN_COMP + (64'sd1 << 37)) >>> 38);
  endfunction

  // Advances the tracker by one item and queues the corrected symbol for data items.
  task automatic track_item(in_item_t it);
    longint si, sq, ti, tq, res, delta;
    logic [63:0] a, b, e, k;
    logic [15:0] ang, d;
    out_item_t exp_item;
    si = it.sample_i; sq = it.sample_q; ti = it.train_i; tq = it.train_q;
    if (it.frame_start) begin
      phase_acc = init_phase_reg;
      gain_b = initial_b_reg;
    end
    a = noise_ratio_reg;
    b = gain_b;
    e = a + b;
    if (it.is_training) begin
      ang = angle_of(si * ti + sq * tq, sq * ti - si * tq);
      d = ang - phase_acc;
      res = longint'($signed(d));
    end else begin
      ang = angle_of(si, sq);
      d = (ang - phase_acc) & 16'h3FFF;
      res = longint'(d) - 8192;
    end
    if (e == 0) begin
      k = 0;
      gain_b = 32'd65536;
    end else begin
      k = (a << 16) / e;
      gain_b = 32'd65536 + 32'((b << 16) / e);
    end
    delta = (longint'(k) * res + 32768) >>> 16;
    phase_acc = phase_acc + delta[15:0];
    if (!it.is_training) begin
      derotate(si, sq, phase_acc, exp_item.out_i, exp_item.out_q);
      exp_item.phase_estimate = phase_acc;
      exp_item.frame_end = it.last_of_frame;
      expected_q.push_back(exp_item);
    end
  endtask

  // Watches the register port and both channels.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      phase_acc = 16'd0;
      gain_b = 32'd65536;
      init_phase_reg = 16'd0;
      noise_ratio_reg = 24'd65536;
      initial_b_reg = 32'd65536;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index_t'(cfg_index))
          CFG_INIT_PHASE:  init_phase_reg = cfg_wdata[15:0];
          CFG_NOISE_RATIO: noise_ratio_reg = cfg_wdata[23:0];
          CFG_INITIAL_B:   initial_b_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%t: unexpected output item %p", $realtime, out_ch.data);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.data.out_i !== want.out_i || out_ch.data.out_q !== want.out_q ||
              out_ch.data.phase_estimate !== want.phase_estimate ||
              out_ch.data.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= 10)
              $display("%t: mismatch expected i=%0d q=%0d ph=%0d end=%0b got i=%0d q=%0d ph=%0d end=%0b",
                       $realtime, want.out_i, want.out_q, want.phase_estimate, want.frame_end,
                       out_ch.data.out_i, out_ch.data.out_q, out_ch.data.phase_estimate,
                       out_ch.data.frame_end);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) track_item(in_ch.data);
    end
    pending = expected_q.size();
  end
endmodule

@@ tb/qpsk_kalman_phase_tracker_core_tb.sv @@
module qpsk_kalman_phase_tracker_core_tb
  import qkpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          errors;
  int          pending;
  int          idle_pct;
  int          stall_pct;
  logic        hold_req;
  logic        hold_done;
  int          hold_left;

  qkpt_in_if  in_ch ();
  qkpt_out_if out_ch ();

  qpsk_kalman_phase_tracker_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  qkpt_tracker_monitor u_mon (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generous overall limit for the run.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off once requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      1: return 16'($signed($urandom_range(200)) - 100);
      2: return ($urandom_range(1) ? 16'sd11585 : -16'sd11585) +
                16'($signed($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item(logic trn, logic fs, logic last);
    in_item_t it;
    it.sample_i = pick_sample();
    it.sample_q = pick_sample();
    it.train_i = pick_sample();
    it.train_q = pick_sample();
    it.is_training = trn;
    it.frame_start = fs;
    it.last_of_frame = last;
    return it;
  endfunction

  // Offers one item and waits for it to be taken.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_fields(logic signed [15:0] si, logic signed [15:0] sq,
                             logic signed [15:0] ti, logic signed [15:0] tq,
                             logic trn, logic fs, logic last);
    in_item_t it;
    it = '{si, sq, ti, tq, trn, fs, last};
    send_item(it);
  endtask

  // Stops offering until every expected result is back and the block is idle.
  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 200000);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] ph, logic [23:0] nr, logic [31:0] b0);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_INIT_PHASE;
    cfg_wdata <= {{16{ph[15]}}, ph};
    @(posedge clk);
    cfg_index <= CFG_NOISE_RATIO;
    cfg_wdata <= {8'd0, nr};
    @(posedge clk);
    cfg_index <= CFG_INITIAL_B;
    cfg_wdata <= b0;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // One frame: optional training prefix, then data symbols; stray items now and then.
  task automatic send_frames(int count);
    int n_trn, n_dat, total;
    for (int f = 0; f < count; f++) begin
      if ($urandom_range(9) == 0)
        send_item(rand_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1))));
      n_trn = $urandom_range(4);
      n_dat = $urandom_range(1, 12);
      total = n_trn + n_dat;
      for (int j = 0; j < total; j++)
        send_item(rand_item(j < n_trn, j == 0, j == total - 1));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_INIT_PHASE;
    cfg_wdata = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset register values.
    send_fields(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0);
    send_fields(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0);
    send_fields(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 1'b0);
    send_fields(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1);
    send_fields(16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sd0, 1'b1, 1'b1, 1'b0);
    send_fields(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 1'b0);
    send_fields(16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0);
    send_fields(16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0);
    send_fields(16'sd0, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
    send_fields(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
    send_fields(-16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585, 1'b1, 1'b0, 1'b1);
    send_fields(16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1);
    send_fields(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0);
    send_fields(16'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1);
    drain();

    // No idling; extreme registers.
    write_regs(16'h8000, 24'd0, 32'hFFFF_FFFF);
    send_frames(12);
    drain();

    // Sender idles often; opposite extremes.
    idle_pct = 46;
    write_regs(16'h7FFF, 24'hFF_FFFF, 32'd65536);
    send_frames(12);
    drain();

    // Receiver stalls often, with one long hold-off while items keep coming.
    idle_pct = 0;
    stall_pct = 46;
    write_regs(16'($urandom), 24'($urandom), 32'd65536 + $urandom_range(32'h00FF_FFFF));
    hold_req <= 1'b1;
    send_frames(12);
    drain();

    // Both sides idle a little; random registers.
    idle_pct = 8;
    stall_pct = 8;
    write_regs(16'($urandom), 24'($urandom_range(32'h0002_0000)), 32'd65536 + $urandom_range(65536));
    send_frames(12);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
